@@ rtl/core/dead_reckoning_pose_integrator_defines.svh @@
// assertion macros for the pose integrator checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef DEAD_RECKONING_POSE_INTEGRATOR_DEFINES_SVH
`define DEAD_RECKONING_POSE_INTEGRATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DRI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define DRI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/dri_pkg.sv @@
// shared types, constants and the arctangent table of the pose integrator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dri_pkg;

    // field widths
    localparam int SPEED_W   = 16;
    localparam int ANGLE_W   = 16;
    localparam int RATE_W    = 24;
    localparam int STEP_T_W  = 16;
    localparam int POS_W     = 32;
    localparam int HEAD_W    = 32;

    // item operation codes
    localparam logic OP_VEL  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // rotator setup
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int ATAN_IDX_W   = 5;
    localparam int ATAN_W       = 30;
    localparam int CW           = 34;
    localparam int PW           = 2 * CW;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    // product rounding, product is Q2.30 * Q8.8 * Q0.16
    localparam int ROUND_SHIFT = 38;
    localparam int DELTA_W     = PW - ROUND_SHIFT;
    localparam logic signed [PW-1:0] ROUND_BIAS = PW'(1) <<< (ROUND_SHIFT - 1);

    typedef logic [STEP_W-1:0] t_step_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VDT,
        S_INIT,
        S_ROT,
        S_FLIP,
        S_MULX,
        S_MULY,
        S_MULH,
        S_ADDH,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        MUL_VDT,
        MUL_X,
        MUL_Y,
        MUL_H
    } t_mul_sel;

    typedef struct packed {
        logic      cordic_init;
        logic      cordic_rot;
        logic      cordic_flip;
        logic      mul_en;
        t_mul_sel  mul_sel;
        logic      vdt_load;
        logic      add_x;
        logic      add_y;
        logic      add_h;
        logic      out_load;
        t_step_idx step;
    } t_dri_ctl;

    // atan(2^-i) in binary angle, 2^32 per turn
    function automatic logic [ATAN_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/dri_if.sv @@
// channel interfaces of the pose integrator: input items, results, step register writes
// depends on dri_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface dri_in_if import dri_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic signed [SPEED_W-1:0]  fwd_speed;
    logic signed [ANGLE_W-1:0]  heading_set;
    logic signed [RATE_W-1:0]   turn_rate;

    modport source (output valid, output op, output fwd_speed, output heading_set,
                    output turn_rate, input ready);
    modport sink   (input valid, input op, input fwd_speed, input heading_set,
                    input turn_rate, output ready);
endinterface

interface dri_out_if import dri_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [POS_W-1:0]    pose_x;
    logic signed [POS_W-1:0]    pose_y;
    logic signed [ANGLE_W-1:0]  pose_heading;

    modport source (output valid, output pose_x, output pose_y, output pose_heading,
                    input ready);
    modport sink   (input valid, input pose_x, input pose_y, input pose_heading,
                    output ready);
endinterface

interface dri_cfg_if import dri_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [STEP_T_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/dri_cordic.sv @@
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on dri_pkg (control struct, gain, arctangent table)
`timescale 1ns / 1ps
`default_nettype none

module dri_cordic import dri_pkg::*; (
    input  logic                  i_clk,
    input  t_dri_ctl              i_ctl,
    input  logic [HEAD_W-1:0]     i_heading,
    output logic signed [CW-1:0]  o_cos,
    output logic signed [CW-1:0]  o_sin
);

    logic signed [CW-1:0] r_x, r_y, r_z;
    logic                 r_flip;
    logic signed [CW-1:0] n_x, n_y, n_z;
    logic                 n_flip;

    logic                 w_flip;
    logic [HEAD_W-1:0]    w_ang;
    logic signed [CW-1:0] w_dx, w_dy, w_atan;

    // fold the outer half turn onto the inner one
    assign w_flip = i_heading[HEAD_W-1] ^ i_heading[HEAD_W-2];
    assign w_ang  = i_heading ^ {w_flip, {(HEAD_W-1){1'b0}}};

    // shared shifter and arctangent lookup
    assign w_dx   = r_y >>> i_ctl.step;
    assign w_dy   = r_x >>> i_ctl.step;
    assign w_atan = signed'(CW'(atan_turn(ATAN_IDX_W'(i_ctl.step))));

    // micro-rotation, start and final sign fix
    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_flip = r_flip;
        if (i_ctl.cordic_init) begin
            n_x    = CORDIC_GAIN;
            n_y    = '0;
            n_z    = CW'(signed'(w_ang));
            n_flip = w_flip;
        end else if (i_ctl.cordic_rot) begin
            if (!r_z[CW-1]) begin
                n_x = r_x - w_dx;
                n_y = r_y + w_dy;
                n_z = r_z - w_atan;
            end else begin
                n_x = r_x + w_dx;
                n_y = r_y - w_dy;
                n_z = r_z + w_atan;
            end
        end else if (i_ctl.cordic_flip && r_flip) begin
            n_x = -r_x;
            n_y = -r_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_flip <= n_flip;
    end

    assign o_cos = r_x;
    assign o_sin = r_y;

endmodule

`default_nettype wire

@@ rtl/core/dri_mul.sv @@
// shared signed multiplier with registered product and the speed-times-step holder
// depends on dri_pkg (control struct, operand select codes)
`timescale 1ns / 1ps
`default_nettype none

module dri_mul import dri_pkg::*; (
    input  logic                       i_clk,
    input  t_dri_ctl                   i_ctl,
    input  logic signed [SPEED_W-1:0]  i_speed,
    input  logic [STEP_T_W-1:0]        i_step_time,
    input  logic signed [RATE_W-1:0]   i_rate,
    input  logic signed [CW-1:0]       i_cos,
    input  logic signed [CW-1:0]       i_sin,
    output logic signed [PW-1:0]       o_prod
);

    logic signed [PW-1:0] r_prod;
    logic signed [CW-1:0] r_vdt;
    logic signed [CW-1:0] w_a, w_b, w_dt;

    assign w_dt = signed'(CW'(i_step_time));

    // operand select
    always_comb begin
        case (i_ctl.mul_sel)
            MUL_VDT: begin
                w_a = CW'(i_speed);
                w_b = w_dt;
            end
            MUL_X: begin
                w_a = i_cos;
                w_b = r_vdt;
            end
            MUL_Y: begin
                w_a = i_sin;
                w_b = r_vdt;
            end
            MUL_H: begin
                w_a = CW'(i_rate);
                w_b = w_dt;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // product register, speed times step kept for both axes
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= w_a * w_b;
        end
        if (i_ctl.vdt_load) begin
            r_vdt <= r_prod[CW-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ rtl/core/dri_seq.sv @@
// sequencer of the tick computation: rotator steps, multiplies and accumulator updates
// depends on dri_pkg (state enum, control struct)
`timescale 1ns / 1ps
`default_nettype none

module dri_seq import dri_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_tick_start,
    input  logic      i_out_free,
    output logic      o_in_ready,
    output t_dri_ctl  o_ctl
);

    localparam t_step_idx LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    t_state    r_state, n_state;
    t_step_idx r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // next state and control
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_ctl      = '0;
        o_ctl.step = r_step;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_tick_start) begin
                    n_state = S_VDT;
                end
            end
            S_VDT: begin
                o_ctl.mul_en  = 1'b1;
                o_ctl.mul_sel = MUL_VDT;
                n_state       = S_INIT;
            end
            S_INIT: begin
                o_ctl.vdt_load    = 1'b1;
                o_ctl.cordic_init = 1'b1;
                n_step            = '0;
                n_state           = S_ROT;
            end
            S_ROT: begin
                o_ctl.cordic_rot = 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_FLIP;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_FLIP: begin
                o_ctl.cordic_flip = 1'b1;
                n_state           = S_MULX;
            end
            S_MULX: begin
                o_ctl.mul_en  = 1'b1;
                o_ctl.mul_sel = MUL_X;
                n_state       = S_MULY;
            end
            S_MULY: begin
                o_ctl.mul_en  = 1'b1;
                o_ctl.mul_sel = MUL_Y;
                o_ctl.add_x   = 1'b1;
                n_state       = S_MULH;
            end
            S_MULH: begin
                o_ctl.mul_en  = 1'b1;
                o_ctl.mul_sel = MUL_H;
                o_ctl.add_y   = 1'b1;
                n_state       = S_ADDH;
            end
            S_ADDH: begin
                o_ctl.add_h = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/dead_reckoning_pose_integrator.sv @@
// Dead-reckoning pose integrator, top level.
// Channels: i_in takes items (op 0 = velocity update, op 1 = tick), o_out gives
// x, y and heading after each tick, i_cfg writes the step time (unsigned Q0.16).
// All channels transfer at a rising clock edge with valid and ready both high.
// A velocity update is absorbed in the cycle it is transferred and gives no result.
// A tick forms speed*step in one shared multiplier, runs the rotator through
// CORDIC_STEPS micro-rotations, then uses the same multiplier for cos*v, sin*v
// and rate*step and adds the heading step; with output space free the result
// is loaded, and i_in.ready comes back the cycle the result is loaded, so a tick
// is taken only once the last result is loaded. The rotator loop is the longest step.
// The result sits in an output register: while the receiver stalls, i_in still
// takes velocity updates, and a following tick waits in its last step until
// the held result is transferred.
// Reset (synchronous, active low) clears pose, speed, rate and heading to zero
// and sets the step time to 3277 (about 0.05 s). i_cfg.ready is always high;
// write it only while no tick is in flight.
// Position saturates at the Q16.16 limits; heading wraps modulo one turn.
`timescale 1ns / 1ps
`default_nettype none

module dead_reckoning_pose_integrator import dri_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dri_in_if.sink      i_in,
    dri_cfg_if.sink     i_cfg,
    dri_out_if.source   o_out
);

    localparam logic [STEP_T_W-1:0] STEP_T_RESET = 16'd3277;

    t_dri_ctl w_ctl;
    logic     w_in_ready, w_in_xfer, w_out_free;

    logic [STEP_T_W-1:0]        r_step_time;
    logic signed [SPEED_W-1:0]  r_speed;
    logic signed [RATE_W-1:0]   r_rate;
    logic [HEAD_W-1:0]          r_heading;
    logic [POS_W-1:0]           r_x_acc, r_y_acc;
    logic                       r_out_valid;
    logic [POS_W-1:0]           r_out_x, r_out_y;
    logic [ANGLE_W-1:0]         r_out_h;

    logic signed [CW-1:0]       w_cos, w_sin;
    logic signed [PW-1:0]       w_prod, w_rnd;
    logic signed [DELTA_W-1:0]  w_delta;

    // saturating add of a rounded step to a Q16.16 accumulator
    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] acc,
                                                 input logic signed [DELTA_W-1:0] d);
        logic signed [POS_W+1:0] sum;
        logic [POS_W-1:0]        res;
        sum = (POS_W+2)'(signed'(acc)) + (POS_W+2)'(d);
        if (sum[POS_W+1:POS_W-1] == 3'b000 || sum[POS_W+1:POS_W-1] == 3'b111) begin
            res = sum[POS_W-1:0];
        end else if (sum[POS_W+1]) begin
            res = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(POS_W-1){1'b1}}};
        end
        return res;
    endfunction

    assign w_in_xfer  = i_in.valid && w_in_ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = w_in_ready;
    assign i_cfg.ready = 1'b1;

    dri_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_start (w_in_xfer && (i_in.op == OP_TICK)),
        .i_out_free   (w_out_free),
        .o_in_ready   (w_in_ready),
        .o_ctl        (w_ctl)
    );

    dri_cordic u_cordic (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_heading (r_heading),
        .o_cos     (w_cos),
        .o_sin     (w_sin)
    );

    dri_mul u_mul (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_speed     (r_speed),
        .i_step_time (r_step_time),
        .i_rate      (r_rate),
        .i_cos       (w_cos),
        .i_sin       (w_sin),
        .o_prod      (w_prod)
    );

    // round half up, drop the fraction below Q16.16
    assign w_rnd   = w_prod + ROUND_BIAS;
    assign w_delta = w_rnd[PW-1:ROUND_SHIFT];

    // motion state, step register and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time <= STEP_T_RESET;
            r_speed     <= '0;
            r_rate      <= '0;
            r_heading   <= '0;
            r_x_acc     <= '0;
            r_y_acc     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_step_time <= i_cfg.data;
            end
            if (w_in_xfer && (i_in.op == OP_VEL)) begin
                r_speed   <= i_in.fwd_speed;
                r_rate    <= i_in.turn_rate;
                r_heading <= {i_in.heading_set, {(HEAD_W-ANGLE_W){1'b0}}};
            end
            if (w_ctl.add_x) begin
                r_x_acc <= sat_add(r_x_acc, w_delta);
            end
            if (w_ctl.add_y) begin
                r_y_acc <= sat_add(r_y_acc, w_delta);
            end
            if (w_ctl.add_h) begin
                r_heading <= r_heading + w_prod[HEAD_W-1:0];
            end
            if (w_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_ctl.out_load) begin
            r_out_x <= r_x_acc;
            r_out_y <= r_y_acc;
            r_out_h <= r_heading[HEAD_W-1:HEAD_W-ANGLE_W];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.pose_x       = r_out_x;
    assign o_out.pose_y       = r_out_y;
    assign o_out.pose_heading = r_out_h;

endmodule

`default_nettype wire

@@ rtl/core/dri_checker.sv @@
// port-level checks of the pose integrator, bound to the top level
// depends on dead_reckoning_pose_integrator_defines.svh for the assertion macros
`timescale 1ns / 1ps
`default_nettype none

`include "dead_reckoning_pose_integrator_defines.svh"

module dri_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_op,
    input logic i_out_valid,
    input logic i_out_ready
);

    // a stalled result stays offered
    `DRI_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    // a tick transfer closes the input until its result is loaded
    `DRI_ASSERT_NEXT(a_tick_busy, i_in_valid && i_in_ready && i_in_op, !i_in_ready, "input open during tick")

    // a velocity update never makes a result
    `DRI_ASSERT_NEXT(a_vel_quiet, i_in_valid && i_in_ready && !i_in_op && !i_out_valid, !i_out_valid, "result after velocity update")

    // a new result comes only out of a running tick
    `DRI_ASSERT_SAME(a_out_from_tick, $rose(i_out_valid), $past(!i_in_ready), "result without tick")

endmodule

bind dead_reckoning_pose_integrator dri_checker u_dri_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.op),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);

`default_nettype wire
